[hdl/aeg_pkg.sv]
// shared types, codes and reset values for the adsr envelope generator
package aeg_pkg;

	localparam int LEVEL_FRAC_BITS_DEF = 16;

	localparam int COEFF_W   = 16;
	localparam int LEVEL16_W = 17;
	localparam int PHASE_W   = 3;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 17;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2,
		OP_CHOKE    = 2'd3
	} op_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_REST    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4,
		PH_CHOKE   = 3'd5
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK_COEFF   = 3'd0,
		REG_DECAY_COEFF    = 3'd1,
		REG_RELEASE_COEFF  = 3'd2,
		REG_CHOKE_COEFF    = 3'd3,
		REG_SUSTAIN_LEVEL  = 3'd4,
		REG_VELOCITY_DEPTH = 3'd5,
		REG_ATTACK_OFFSET  = 3'd6,
		REG_FALL_OFFSET    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [COEFF_W-1:0]   attack_coeff;
		logic [COEFF_W-1:0]   decay_coeff;
		logic [COEFF_W-1:0]   release_coeff;
		logic [COEFF_W-1:0]   choke_coeff;
		logic [LEVEL16_W-1:0] sustain_level;
		logic [LEVEL16_W-1:0] velocity_depth;
		logic [LEVEL16_W-1:0] attack_offset;
		logic [LEVEL16_W-1:0] fall_offset;
	} cfg_t;

	localparam logic [COEFF_W-1:0]   RST_ATTACK_COEFF   = 16'd64000;
	localparam logic [COEFF_W-1:0]   RST_DECAY_COEFF    = 16'd65000;
	localparam logic [COEFF_W-1:0]   RST_RELEASE_COEFF  = 16'd65200;
	localparam logic [COEFF_W-1:0]   RST_CHOKE_COEFF    = 16'd60000;
	localparam logic [LEVEL16_W-1:0] RST_SUSTAIN_LEVEL  = 17'd52429;
	localparam logic [LEVEL16_W-1:0] RST_VELOCITY_DEPTH = 17'd19661;
	localparam logic [LEVEL16_W-1:0] RST_ATTACK_OFFSET  = 17'd6554;
	localparam logic [LEVEL16_W-1:0] RST_FALL_OFFSET    = 17'd655;

endpackage

[hdl/adsr_envelope_generator_core.sv]
// Exponential ADSR envelope for one voice. Note-on, note-off and choke items take effect in
// the cycle they are accepted and give no result. A tick item gives one level sample; its
// work runs through one shared bit-serial multiplier that takes one multiplier bit per cycle,
// used for velocity scaling, the sustain target and the one-pole step in decay and sustain,
// for velocity scaling and the step in attack, for the step alone in release and choke, and
// not at rest. Input is taken again once the result sits in the output register.
module adsr_envelope_generator_core #(
	parameter int LEVEL_FRAC_BITS = aeg_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [aeg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // note_velocity[16:0]
	input  logic [aeg_pkg::OP_W-1:0]           s_axis_tuser,  // operation[1:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [aeg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // level[16:0], phase_now[19:17], at_rest[20]
	input  logic                               cfg_we,
	input  logic [aeg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aeg_pkg::CFG_W-1:0]          cfg_data
);

	localparam int F     = LEVEL_FRAC_BITS;
	localparam int AW    = F + 4;
	localparam int BW    = (F + 1 > 16) ? F + 1 : 16;
	localparam int PW    = AW + BW;
	localparam int UP_SH = (F >= 16) ? F - 16 : 0;
	localparam int DN_SH = (F < 16) ? 16 - F : 0;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
	localparam int COEFF_SEL_W = aeg_pkg::COEFF_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_VS,
		ST_AIM,
		ST_TG,
		ST_OPST,
		ST_OP,
		ST_FIN,
		ST_OUT
	} state_t;

	function automatic logic [F:0] from16(input logic [16:0] x);
		logic [F+16:0] w;
		w = ({{F{1'b0}}, x} << UP_SH) >> DN_SH;
		return w[F:0];
	endfunction

	function automatic logic [F:0] sat_one(input logic [F:0] x);
		return (x > ONE) ? ONE : x;
	endfunction

	function automatic logic [16:0] to16(input logic [F:0] x);
		logic [F+16:0] w;
		w = ({16'b0, x} >> UP_SH) << DN_SH;
		return w[16:0];
	endfunction

	aeg_pkg::cfg_t   cfg;
	state_t          state_q;
	aeg_pkg::phase_t phase_q;
	logic [F:0]      env_q;
	logic [16:0]     held_q;
	logic [F:0]      tgt_q;
	logic signed [AW-1:0] aim_q;
	logic [F+1:0]    new_q;
	logic            m_valid_q;
	logic [aeg_pkg::OUT_TDATA_W-1:0] m_data_q;

	logic                 mul_start;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0]        mul_b;
	logic                 mul_done;
	logic signed [PW-1:0] prod;

	logic [F:0]           d_sat;
	logic [F:0]           v_sat;
	logic [F:0]           sus_sat;
	logic signed [AW-1:0] atk_s;
	logic signed [AW-1:0] fall_s;
	logic                 active;
	logic [F:0]           prod_hi;
	logic [F+1:0]         scale_sum;
	logic signed [AW-1:0] diff;
	logic signed [AW-1:0] aim_att;
	logic signed [AW-1:0] aim_fall;
	logic [COEFF_SEL_W-1:0] k_sel;
	logic signed [AW-1:0] prod_shr;
	logic signed [AW:0]   r_sum;
	logic [F+1:0]         new_nx;
	logic                 s_accept;
	logic                 out_load;
	aeg_pkg::op_t         op;

	aeg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aeg_serial_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	assign d_sat   = sat_one(from16(cfg.velocity_depth));
	assign v_sat   = sat_one(from16(held_q));
	assign sus_sat = sat_one(from16(cfg.sustain_level));
	assign atk_s   = $signed(AW'(from16(cfg.attack_offset)));
	assign fall_s  = $signed(AW'(from16(cfg.fall_offset)));

	assign active = (phase_q == aeg_pkg::PH_ATTACK) || (phase_q == aeg_pkg::PH_DECAY) ||
		(phase_q == aeg_pkg::PH_SUSTAIN);

	// product scaled back by the fractional bits
	assign prod_hi   = prod[F +: F+1];
	assign scale_sum = (F+2)'(ONE) - (F+2)'(d_sat) + (F+2)'(prod_hi);

	assign aim_att  = $signed(AW'(tgt_q)) + atk_s;
	assign aim_fall = (phase_q == aeg_pkg::PH_DECAY) ?
		($signed(AW'(prod_hi)) - fall_s) : $signed(AW'(prod_hi));
	assign diff     = $signed(AW'(env_q)) - aim_q;

	always_comb begin
		case (phase_q)
			aeg_pkg::PH_ATTACK:  k_sel = cfg.attack_coeff;
			aeg_pkg::PH_RELEASE: k_sel = cfg.release_coeff;
			aeg_pkg::PH_CHOKE:   k_sel = cfg.choke_coeff;
			default:             k_sel = cfg.decay_coeff;
		endcase
	end

	// one-pole step: aim + round(k*(level-aim) / 2^16), clamped at zero
	assign prod_shr = prod[16 +: AW];
	assign r_sum    = {aim_q[AW-1], aim_q} + {prod_shr[AW-1], prod_shr} +
		$signed({{AW{1'b0}}, prod[15]});
	assign new_nx   = r_sum[AW] ? '0 : r_sum[F+1:0];

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_SETUP: begin
				mul_start = active;
				mul_a     = $signed(AW'(d_sat));
				mul_b     = BW'(v_sat);
			end
			ST_AIM: begin
				mul_start = (phase_q != aeg_pkg::PH_ATTACK);
				mul_a     = $signed(AW'(sus_sat));
				mul_b     = BW'(tgt_q);
			end
			ST_OPST: begin
				mul_start = 1'b1;
				mul_a     = diff;
				mul_b     = BW'(k_sel);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign op       = aeg_pkg::op_t'(s_axis_tuser);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= aeg_pkg::PH_REST;
			env_q     <= '0;
			held_q    <= '0;
			tgt_q     <= '0;
			aim_q     <= '0;
			new_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						unique case (op)
							aeg_pkg::OP_TICK: state_q <= ST_SETUP;
							aeg_pkg::OP_NOTE_ON: begin
								phase_q <= aeg_pkg::PH_ATTACK;
								held_q  <= s_axis_tdata[16:0];
							end
							aeg_pkg::OP_NOTE_OFF: begin
								if (active) phase_q <= aeg_pkg::PH_RELEASE;
							end
							aeg_pkg::OP_CHOKE: begin
								if (active) phase_q <= aeg_pkg::PH_CHOKE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SETUP: begin
					unique case (phase_q) inside
						aeg_pkg::PH_ATTACK, aeg_pkg::PH_DECAY, aeg_pkg::PH_SUSTAIN: begin
							state_q <= ST_VS;
						end
						aeg_pkg::PH_RELEASE, aeg_pkg::PH_CHOKE: begin
							aim_q   <= -fall_s;
							state_q <= ST_OPST;
						end
						aeg_pkg::PH_REST: state_q <= ST_OUT;
						default: begin
							phase_q <= aeg_pkg::PH_REST;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_VS: begin
					if (mul_done) begin
						tgt_q   <= scale_sum[F:0];
						state_q <= ST_AIM;
					end
				end
				ST_AIM: begin
					if (phase_q == aeg_pkg::PH_ATTACK) begin
						aim_q   <= aim_att;
						state_q <= ST_OPST;
					end else begin
						state_q <= ST_TG;
					end
				end
				ST_TG: begin
					if (mul_done) begin
						tgt_q   <= prod_hi;
						aim_q   <= aim_fall;
						state_q <= ST_OPST;
					end
				end
				ST_OPST: state_q <= ST_OP;
				ST_OP: begin
					if (mul_done) begin
						new_q   <= new_nx;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					unique case (phase_q) inside
						aeg_pkg::PH_ATTACK: begin
							if (new_q >= (F+2)'(tgt_q)) begin
								env_q   <= tgt_q;
								phase_q <= aeg_pkg::PH_DECAY;
							end else begin
								env_q <= new_q[F:0];
							end
						end
						aeg_pkg::PH_DECAY: begin
							env_q <= new_q[F:0];
							if (new_q <= (F+2)'(sus_sat)) phase_q <= aeg_pkg::PH_SUSTAIN;
						end
						aeg_pkg::PH_RELEASE, aeg_pkg::PH_CHOKE: begin
							env_q <= new_q[F:0];
							if (new_q == '0) phase_q <= aeg_pkg::PH_REST;
						end
						default: env_q <= new_q[F:0];
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						m_data_q  <= {3'b000, (phase_q == aeg_pkg::PH_REST), phase_q,
							to16(env_q)};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[hdl/aeg_cfg_regs.sv]
// configuration register file of the adsr envelope generator
module aeg_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aeg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aeg_pkg::CFG_W-1:0]        cfg_data,
	output aeg_pkg::cfg_t                    cfg
);

	aeg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_coeff   <= aeg_pkg::RST_ATTACK_COEFF;
			cfg_q.decay_coeff    <= aeg_pkg::RST_DECAY_COEFF;
			cfg_q.release_coeff  <= aeg_pkg::RST_RELEASE_COEFF;
			cfg_q.choke_coeff    <= aeg_pkg::RST_CHOKE_COEFF;
			cfg_q.sustain_level  <= aeg_pkg::RST_SUSTAIN_LEVEL;
			cfg_q.velocity_depth <= aeg_pkg::RST_VELOCITY_DEPTH;
			cfg_q.attack_offset  <= aeg_pkg::RST_ATTACK_OFFSET;
			cfg_q.fall_offset    <= aeg_pkg::RST_FALL_OFFSET;
		end else if (cfg_we) begin
			unique case (aeg_pkg::cfg_idx_t'(cfg_index))
				aeg_pkg::REG_ATTACK_COEFF:   cfg_q.attack_coeff   <= cfg_data[15:0];
				aeg_pkg::REG_DECAY_COEFF:    cfg_q.decay_coeff    <= cfg_data[15:0];
				aeg_pkg::REG_RELEASE_COEFF:  cfg_q.release_coeff  <= cfg_data[15:0];
				aeg_pkg::REG_CHOKE_COEFF:    cfg_q.choke_coeff    <= cfg_data[15:0];
				aeg_pkg::REG_SUSTAIN_LEVEL:  cfg_q.sustain_level  <= cfg_data;
				aeg_pkg::REG_VELOCITY_DEPTH: cfg_q.velocity_depth <= cfg_data;
				aeg_pkg::REG_ATTACK_OFFSET:  cfg_q.attack_offset  <= cfg_data;
				aeg_pkg::REG_FALL_OFFSET:    cfg_q.fall_offset    <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/aeg_serial_mul.sv]
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
module aeg_serial_mul #(
	parameter int AW = 20,
	parameter int BW = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [AW-1:0]    a,
	input  logic        [BW-1:0]    b,
	output logic                    done,
	output logic signed [AW+BW-1:0] prod
);

	localparam int CW = $clog2(BW + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [AW-1:0] a_q;
	logic signed [AW:0]   hi_q;
	logic [BW-1:0]        lo_q;
	logic signed [AW:0]   sum;

	// multiplier bits leave lo one per cycle, product bits shift in behind them
	assign sum = lo_q[0] ? (hi_q + {a_q[AW-1], a_q}) : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[AW], sum[AW:1]};
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q[AW-1:0], lo_q};

endmodule

[hdl/aeg_checker.sv]
// port-level checks for the adsr envelope generator, bound to the top level
module aeg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [aeg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	// rest flag agrees with the phase code
	a_rest_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[20] == (m_axis_tdata[19:17] == 3'(aeg_pkg::PH_REST))))
		else $error("at_rest disagrees with phase_now");

	// level is zero whenever the envelope rests
	a_rest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[16:0] == 17'd0))
		else $error("nonzero level at rest");

	// level never above full scale
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd65536))
		else $error("level above full scale");

	// no item produces a result in the cycle right after it is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result appeared too early");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("output changed while stalled");

endmodule

bind adsr_envelope_generator_core aeg_checker u_aeg_checker (.*);
